/* rtl/core/ppd_pkg.sv */
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared widths, register indexes, reset values and types of the pulse pair
// decoder.
// ----------------------------------------------------------------------------
package ppd_pkg;

    // Code register width (8 to 64 bits supported)
    localparam int CODE_WIDTH  = 64;

    localparam int PULSE_W     = 16;
    localparam int PCT_W       = 7;
    localparam int CNT_W       = 7;
    localparam int PROTO_W     = 8;
    localparam int CODE_OUT_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = PULSE_W + PCT_W;      // short_time * percent
    localparam int SCALED_W    = PULSE_W + 1 + PCT_W;  // (gap + 1) * 100

    localparam int TOL_FLOOR   = 150;
    localparam int PCT_SCALE   = 100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_PERCENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_NEEDED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_ID = 3'd4;

    // Reset values
    localparam logic [PULSE_W-1:0] RST_SHORT_TIME  = 16'd400;
    localparam logic [PULSE_W-1:0] RST_LONG_TIME   = 16'd1200;
    localparam logic [PCT_W-1:0]   RST_TOL_PERCENT = 7'd30;
    localparam logic [CNT_W-1:0]   RST_BITS_NEEDED = 7'd24;
    localparam logic [PROTO_W-1:0] RST_PROTOCOL_ID = 8'd0;

    localparam logic [CNT_W-1:0]   CODE_WIDTH_CNT  = CNT_W'(CODE_WIDTH);

    typedef logic [CODE_OUT_W-1:0] t_code_out;
    typedef logic [CODE_WIDTH-1:0] t_code;

    // Settings as seen by the decoder datapath
    typedef struct packed {
        logic [PULSE_W-1:0] short_time;
        logic [PULSE_W-1:0] long_time;
        logic [PROD_W-1:0]  tol_product;   // short_time * tolerance_percent
        logic [CNT_W-1:0]   need;          // bits_needed clamped to CODE_WIDTH
        logic [PROTO_W-1:0] protocol_id;
    } t_cfg;

endpackage

/* rtl/core/ppd_pulse_if.sv */
// ----------------------------------------------------------------------------
// ppd_pulse_if
// Pulse duration channel: one pulse per transfer, high and low alternating.
// ----------------------------------------------------------------------------
interface ppd_pulse_if;
    logic                        valid;
    logic                        ready;
    logic [ppd_pkg::PULSE_W-1:0] pulse_us;
    logic                        first_pulse;
    logic                        last_pulse;

    modport source (output valid, output pulse_us, output first_pulse,
                    output last_pulse, input ready);
    modport sink   (input valid, input pulse_us, input first_pulse,
                    input last_pulse, output ready);
endinterface

/* rtl/core/ppd_result_if.sv */
// ----------------------------------------------------------------------------
// ppd_result_if
// Decode result channel: one decoded frame or failure per transfer.
// ----------------------------------------------------------------------------
interface ppd_result_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    ppd_pkg::t_code_out          code;
    logic [ppd_pkg::CNT_W-1:0]   bit_length;
    logic [ppd_pkg::PROTO_W-1:0] protocol;

    modport source (output valid, output status, output code,
                    output bit_length, output protocol, input ready);
    modport sink   (input valid, input status, input code,
                    input bit_length, input protocol, output ready);
endinterface

/* rtl/core/ppd_cfg.sv */
// ----------------------------------------------------------------------------
// ppd_cfg
// Configuration registers. Keeps short_time * tolerance_percent up to date
// so the decoder compares against the tolerance without a divider.
// ----------------------------------------------------------------------------
module ppd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ppd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ppd_pkg::t_cfg                 o_cfg
);

    logic [ppd_pkg::PULSE_W-1:0] r_short_time;
    logic [ppd_pkg::PULSE_W-1:0] r_long_time;
    logic [ppd_pkg::PCT_W-1:0]   r_tol_percent;
    logic [ppd_pkg::CNT_W-1:0]   r_need;
    logic [ppd_pkg::PROTO_W-1:0] r_protocol_id;
    logic [ppd_pkg::PROD_W-1:0]  r_tol_product;

    logic [ppd_pkg::PULSE_W-1:0] mul_a;
    logic [ppd_pkg::PCT_W-1:0]   mul_b;
    logic [ppd_pkg::PROD_W-1:0]  n_tol_product;
    logic [ppd_pkg::CNT_W-1:0]   wr_need;
    logic [ppd_pkg::CNT_W-1:0]   n_need;

    // One small multiplier, operands taken from the write in progress
    always_comb begin
        mul_a = (i_cfg_idx == ppd_pkg::REG_SHORT_TIME)
              ? i_cfg_data[ppd_pkg::PULSE_W-1:0] : r_short_time;
        mul_b = (i_cfg_idx == ppd_pkg::REG_TOL_PERCENT)
              ? i_cfg_data[ppd_pkg::PCT_W-1:0] : r_tol_percent;
        n_tol_product = ppd_pkg::PROD_W'(mul_a) * ppd_pkg::PROD_W'(mul_b);
        wr_need = i_cfg_data[ppd_pkg::CNT_W-1:0];
        n_need  = (wr_need > ppd_pkg::CODE_WIDTH_CNT) ? ppd_pkg::CODE_WIDTH_CNT : wr_need;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_time  <= ppd_pkg::RST_SHORT_TIME;
            r_long_time   <= ppd_pkg::RST_LONG_TIME;
            r_tol_percent <= ppd_pkg::RST_TOL_PERCENT;
            r_need        <= ppd_pkg::RST_BITS_NEEDED;
            r_protocol_id <= ppd_pkg::RST_PROTOCOL_ID;
            r_tol_product <= ppd_pkg::PROD_W'(ppd_pkg::RST_SHORT_TIME)
                           * ppd_pkg::PROD_W'(ppd_pkg::RST_TOL_PERCENT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppd_pkg::REG_SHORT_TIME: begin
                    r_short_time  <= i_cfg_data[ppd_pkg::PULSE_W-1:0];
                    r_tol_product <= n_tol_product;
                end
                ppd_pkg::REG_LONG_TIME: begin
                    r_long_time <= i_cfg_data[ppd_pkg::PULSE_W-1:0];
                end
                ppd_pkg::REG_TOL_PERCENT: begin
                    r_tol_percent <= i_cfg_data[ppd_pkg::PCT_W-1:0];
                    r_tol_product <= n_tol_product;
                end
                ppd_pkg::REG_BITS_NEEDED: begin
                    r_need <= n_need;
                end
                ppd_pkg::REG_PROTOCOL_ID: begin
                    r_protocol_id <= i_cfg_data[ppd_pkg::PROTO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.short_time  = r_short_time;
    assign o_cfg.long_time   = r_long_time;
    assign o_cfg.tol_product = r_tol_product;
    assign o_cfg.need        = r_need;
    assign o_cfg.protocol_id = r_protocol_id;

endmodule

/* rtl/core/ppd_match.sv */
// ----------------------------------------------------------------------------
// ppd_match
// Window test: |pulse - nominal| < max(product / 100, 150), evaluated as
// gap < 150 or (gap + 1) * 100 <= product.
// ----------------------------------------------------------------------------
module ppd_match (
    input  logic [ppd_pkg::PULSE_W-1:0] i_pulse,
    input  logic [ppd_pkg::PULSE_W-1:0] i_nominal,
    input  logic [ppd_pkg::PROD_W-1:0]  i_tol_product,
    output logic                        o_hit
);

    logic [ppd_pkg::PULSE_W-1:0]  gap;
    logic [ppd_pkg::SCALED_W-1:0] gap_inc;
    logic [ppd_pkg::SCALED_W-1:0] scaled;

    always_comb begin
        gap     = (i_pulse > i_nominal) ? (i_pulse - i_nominal) : (i_nominal - i_pulse);
        gap_inc = ppd_pkg::SCALED_W'(gap) + ppd_pkg::SCALED_W'(1);
        scaled  = gap_inc * ppd_pkg::SCALED_W'(ppd_pkg::PCT_SCALE);
        o_hit   = (gap < ppd_pkg::PULSE_W'(ppd_pkg::TOL_FLOOR))
               || (scaled <= ppd_pkg::SCALED_W'(i_tol_product));
    end

endmodule

/* rtl/core/ppd_core.sv */
// ----------------------------------------------------------------------------
// ppd_core
// Pair tracking, bit shifting, frame completion and the result register.
// ----------------------------------------------------------------------------
module ppd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppd_pkg::t_cfg      i_cfg,
    ppd_pulse_if.sink          i_pulse,
    ppd_result_if.source       o_result
);

    logic                        r_done;
    logic                        r_phase;
    logic [ppd_pkg::PULSE_W-1:0] r_held;
    ppd_pkg::t_code              r_code;
    logic [ppd_pkg::CNT_W-1:0]   r_cnt;

    logic                        r_out_valid;
    logic                        r_status;
    ppd_pkg::t_code_out          r_out_code;
    logic [ppd_pkg::CNT_W-1:0]   r_out_len;
    logic [ppd_pkg::PROTO_W-1:0] r_out_proto;

    logic                        n_done;
    logic                        n_phase;
    logic [ppd_pkg::PULSE_W-1:0] n_held;
    ppd_pkg::t_code              n_code;
    logic [ppd_pkg::CNT_W-1:0]   n_cnt;
    logic                        n_out_valid;

    logic acc;
    logic live_phase;
    ppd_pkg::t_code            live_code;
    logic [ppd_pkg::CNT_W-1:0] live_cnt;
    logic check_end;
    logic emit;
    logic emit_ok;
    logic hi_short, hi_long, lo_short, lo_long;
    logic bit_one, bit_zero;

    assign i_pulse.ready = !r_out_valid || o_result.ready;
    assign acc = i_pulse.valid && i_pulse.ready;

    ppd_match u_hi_short (.i_pulse(r_held), .i_nominal(i_cfg.short_time),
                          .i_tol_product(i_cfg.tol_product), .o_hit(hi_short));
    ppd_match u_hi_long  (.i_pulse(r_held), .i_nominal(i_cfg.long_time),
                          .i_tol_product(i_cfg.tol_product), .o_hit(hi_long));
    ppd_match u_lo_short (.i_pulse(i_pulse.pulse_us), .i_nominal(i_cfg.short_time),
                          .i_tol_product(i_cfg.tol_product), .o_hit(lo_short));
    ppd_match u_lo_long  (.i_pulse(i_pulse.pulse_us), .i_nominal(i_cfg.long_time),
                          .i_tol_product(i_cfg.tol_product), .o_hit(lo_long));

    // Bit one takes priority when both patterns fit
    assign bit_one  = hi_short && lo_long;
    assign bit_zero = hi_long && lo_short;

    always_comb begin
        n_done    = r_done;
        n_phase   = r_phase;
        n_held    = r_held;
        n_code    = r_code;
        n_cnt     = r_cnt;
        emit      = 1'b0;
        emit_ok   = 1'b0;
        check_end = 1'b0;

        live_phase = i_pulse.first_pulse ? 1'b0 : r_phase;
        live_code  = i_pulse.first_pulse ? '0 : r_code;
        live_cnt   = i_pulse.first_pulse ? '0 : r_cnt;

        if (acc && (i_pulse.first_pulse || !r_done)) begin
            n_done = 1'b0;
            n_code = live_code;
            n_cnt  = live_cnt;
            if (!live_phase) begin
                // high pulse: hold it until its low partner arrives
                n_held    = i_pulse.pulse_us;
                n_phase   = 1'b1;
                check_end = 1'b1;
            end else begin
                n_phase = 1'b0;
                if (bit_one || bit_zero) begin
                    n_code    = {live_code[ppd_pkg::CODE_WIDTH-2:0], bit_one};
                    n_cnt     = live_cnt + ppd_pkg::CNT_W'(1);
                    check_end = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            if (check_end) begin
                if (n_cnt >= i_cfg.need) begin
                    emit    = 1'b1;
                    emit_ok = 1'b1;
                end else if (i_pulse.last_pulse) begin
                    emit = 1'b1;
                end
            end
            if (emit) begin
                n_done = 1'b1;
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b1;
            r_phase     <= 1'b0;
            r_code      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_done      <= n_done;
            r_phase     <= n_phase;
            r_code      <= n_code;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (emit) begin
            r_status    <= !emit_ok;
            r_out_code  <= emit_ok ? ppd_pkg::t_code_out'(n_code) : '0;
            r_out_len   <= emit_ok ? n_cnt : '0;
            r_out_proto <= emit_ok ? i_cfg.protocol_id : '0;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_status;
    assign o_result.code       = r_out_code;
    assign o_result.bit_length = r_out_len;
    assign o_result.protocol   = r_out_proto;

`ifndef NO_ASSERTIONS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status) |->
            (r_out_code == '0 && r_out_len == '0 && r_out_proto == '0))
        else $error("failure result carries nonzero fields");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ppd_pkg::CODE_WIDTH_CNT)
        else $error("bit counter ran past the code width");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_status) |-> (r_out_len <= ppd_pkg::CODE_WIDTH_CNT))
        else $error("decoded length exceeds code width");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_pulse.first_pulse && r_done) |=> !r_out_valid)
        else $error("result produced while waiting for a first pulse");
`endif

endmodule

/* rtl/core/pwm_pulse_pair_decoder.sv */
// ----------------------------------------------------------------------------
// pwm_pulse_pair_decoder
// Inverted-PWM pulse pair decoder for on-off keyed captures.
//
// Pulse durations (us) arrive one per transfer, high and low alternating,
// with first_pulse marking the start of a capture. Each high/low pair is
// one bit: short high + long low is 1, long high + short low is 0, within a
// tolerance of short_time * tolerance_percent / 100 (never below 150 us).
// When bits_needed bits are in, one success result carries the code (first
// bit most significant), its length and protocol_id; a pair that fits
// neither pattern, or last_pulse before enough bits, gives one failure
// result with zero fields. After any result the decoder ignores pulses until
// the next first_pulse. Throughput is one pulse per clock: the pair logic
// is a single registered stage and a result is visible the cycle after the
// pulse that completes it. The input stalls only while the result register
// is full and the downstream side holds ready low. Configuration writes take
// effect on the next cycle; the tolerance product is updated along with the
// write, so a pulse may follow a write immediately.
// ----------------------------------------------------------------------------
module pwm_pulse_pair_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ppd_pulse_if.sink                      i_pulse,
    ppd_result_if.source                   o_result
);

    ppd_pkg::t_cfg cfg;

    // settings plus the precomputed tolerance product
    ppd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // pair tracking, bit shifter and result register
    ppd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_pulse  (i_pulse),
        .o_result (o_result)
    );

endmodule

/* sim/pwm_pulse_pair_decoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_pulse_pair_decoder_test
// Self-checking bench for the pulse pair decoder. Pulse captures are driven
// through the pulse channel, and a bench-side decoder predicts every result
// frame. Each result transfer is checked field by field against the oldest
// prediction. Directed cases come first, then a held-off output, then random
// captures under several register setups and handshake idling patterns.
// ----------------------------------------------------------------------------
module pwm_pulse_pair_decoder_test;

    // One result frame as the bench expects it
    typedef struct packed {
        logic                            status;
        logic [ppd_pkg::CODE_OUT_W-1:0]  code;
        logic [ppd_pkg::CNT_W-1:0]       bit_length;
        logic [ppd_pkg::PROTO_W-1:0]     protocol;
    } t_frame;

    // One pulse transfer
    typedef struct packed {
        logic [ppd_pkg::PULSE_W-1:0] dur;
        logic                        first;
        logic                        last;
    } t_pulse;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ppd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ppd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ppd_pulse_if  pulse_ch ();
    ppd_result_if result_ch ();

    pwm_pulse_pair_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pulse    (pulse_ch),
        .o_result   (result_ch)
    );

    // ------------------------------------------------------------------
    // Bench copy of the decoder: settings and per-capture state
    // ------------------------------------------------------------------
    logic [ppd_pkg::PULSE_W-1:0] cfg_short;
    logic [ppd_pkg::PULSE_W-1:0] cfg_long;
    logic [ppd_pkg::PCT_W-1:0]   cfg_pct;
    logic [ppd_pkg::CNT_W-1:0]   cfg_need;
    logic [ppd_pkg::PROTO_W-1:0] cfg_proto;

    logic [ppd_pkg::PULSE_W-1:0] st_high_held;
    logic                        st_low_next;   // next pulse closes a pair
    ppd_pkg::t_code              st_code;
    logic [ppd_pkg::CNT_W-1:0]   st_count;
    logic                        st_idle;       // waiting for a first pulse
    logic                        pulse_ignored; // last pulse fell into the idle state

    t_frame expected_frames[$];
    t_frame oldest;

    // Handshake shaping
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold;

    // Bookkeeping
    int error_count;
    int results_checked;
    int frames_ok;
    int frames_failed;
    int counted_pulses;
    int setups_loaded;

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Timeout: decoder stopped making progress");
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    task automatic reset_model();
        cfg_short     = ppd_pkg::RST_SHORT_TIME;
        cfg_long      = ppd_pkg::RST_LONG_TIME;
        cfg_pct       = ppd_pkg::RST_TOL_PERCENT;
        cfg_need      = ppd_pkg::RST_BITS_NEEDED;
        cfg_proto     = ppd_pkg::RST_PROTOCOL_ID;
        st_high_held  = '0;
        st_low_next   = 1'b0;
        st_code       = '0;
        st_count      = '0;
        st_idle       = 1'b1;
        pulse_ignored = 1'b0;
    endtask

    // Match window: short_time * percent / 100 at full width, never below the floor
    function automatic int unsigned match_window();
        int unsigned tol;
        tol = (int'(cfg_short) * int'(cfg_pct)) / ppd_pkg::PCT_SCALE;
        return (tol < ppd_pkg::TOL_FLOOR) ? ppd_pkg::TOL_FLOOR : tol;
    endfunction

    function automatic bit near(input int unsigned a, input int unsigned b,
                                input int unsigned tol);
        return ((a > b) ? a - b : b - a) < tol;
    endfunction

    function automatic int unsigned bits_to_complete();
        return (cfg_need > ppd_pkg::CODE_WIDTH) ? ppd_pkg::CODE_WIDTH : cfg_need;
    endfunction

    // Advances the bench decoder by one pulse; returns 1 when a frame comes out
    function automatic bit decode_pulse(input logic [ppd_pkg::PULSE_W-1:0] dur,
                                        input logic first, input logic last,
                                        output t_frame res);
        int unsigned tol;
        bit          is_one;
        bit          is_zero;
        res = '0;
        if (first) begin
            st_high_held = '0;
            st_low_next  = 1'b0;
            st_code      = '0;
            st_count     = '0;
            st_idle      = 1'b0;
        end
        pulse_ignored = st_idle;
        if (st_idle)
            return 1'b0;

        if (!st_low_next) begin
            st_high_held = dur;
            st_low_next  = 1'b1;
        end else begin
            st_low_next = 1'b0;
            tol     = match_window();
            st_code = st_code << 1;
            // short high + long low is a one and wins when both patterns fit
            is_one  = near(st_high_held, cfg_short, tol) && near(dur, cfg_long, tol);
            is_zero = near(st_high_held, cfg_long, tol) && near(dur, cfg_short, tol);
            if (is_one) begin
                st_code[0] = 1'b1;
            end else if (!is_zero) begin
                st_idle    = 1'b1;
                res.status = 1'b1;
                return 1'b1;
            end
            st_count = st_count + 1'b1;
        end

        if (st_count >= bits_to_complete()) begin
            st_idle        = 1'b1;
            res.status     = 1'b0;
            res.code       = ppd_pkg::CODE_OUT_W'(st_code);
            res.bit_length = st_count;
            res.protocol   = cfg_proto;
            return 1'b1;
        end
        if (last) begin
            // capture ended short of the bit count, odd trailing pulse included
            st_idle    = 1'b1;
            res.status = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready pattern and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            result_ch.ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t ns: unexpected result: status=%0b code=%h bits=%0d protocol=%0d",
                         $time, result_ch.status, result_ch.code, result_ch.bit_length,
                         result_ch.protocol);
                error_count++;
            end else begin
                oldest = expected_frames.pop_front();
                if (result_ch.status !== oldest.status || result_ch.code !== oldest.code ||
                    result_ch.bit_length !== oldest.bit_length ||
                    result_ch.protocol !== oldest.protocol) begin
                    $display("%0t ns: mismatch: expected status=%0b code=%h bits=%0d proto=%0d",
                             $time, oldest.status, oldest.code, oldest.bit_length,
                             oldest.protocol);
                    $display("%0t ns:           actual status=%0b code=%h bits=%0d proto=%0d",
                             $time, result_ch.status, result_ch.code, result_ch.bit_length,
                             result_ch.protocol);
                    error_count++;
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One pulse transfer; valid stays up afterwards so the next pulse can follow
    // back to back. The prediction runs at the accepting edge.
    task automatic send_pulse(input logic [ppd_pkg::PULSE_W-1:0] dur, input logic first,
                              input logic last);
        t_frame res;
        while ($urandom_range(99) < tx_idle_pct) begin
            pulse_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pulse_ch.valid       <= 1'b1;
        pulse_ch.pulse_us    <= dur;
        pulse_ch.first_pulse <= first;
        pulse_ch.last_pulse  <= last;
        do @(posedge i_clk); while (!pulse_ch.ready);
        if (decode_pulse(dur, first, last, res)) begin
            expected_frames.push_back(res);
            if (res.status)
                frames_failed++;
            else
                frames_ok++;
        end
        if (!pulse_ignored)
            counted_pulses++;
    endtask

    // Drops valid, waits until every predicted frame has come out, then lets a
    // pulse that produces nothing but is still in the stage pass through.
    task automatic settle();
        pulse_ch.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ppd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            ppd_pkg::REG_SHORT_TIME:  cfg_short = data;
            ppd_pkg::REG_LONG_TIME:   cfg_long  = data;
            ppd_pkg::REG_TOL_PERCENT: cfg_pct   = data[ppd_pkg::PCT_W-1:0];
            ppd_pkg::REG_BITS_NEEDED: cfg_need  = data[ppd_pkg::CNT_W-1:0];
            ppd_pkg::REG_PROTOCOL_ID: cfg_proto = data[ppd_pkg::PROTO_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all five registers; only called with the decoder drained
    task automatic load_settings(input int unsigned st, input int unsigned lt,
                                 input int unsigned pct, input int unsigned need,
                                 input int unsigned proto);
        write_reg(ppd_pkg::REG_SHORT_TIME,  ppd_pkg::CFG_DATA_W'(st));
        write_reg(ppd_pkg::REG_LONG_TIME,   ppd_pkg::CFG_DATA_W'(lt));
        write_reg(ppd_pkg::REG_TOL_PERCENT, ppd_pkg::CFG_DATA_W'(pct));
        write_reg(ppd_pkg::REG_BITS_NEEDED, ppd_pkg::CFG_DATA_W'(need));
        write_reg(ppd_pkg::REG_PROTOCOL_ID, ppd_pkg::CFG_DATA_W'(proto));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        setups_loaded++;
    endtask

    // Duration around a nominal time; now and then exactly on or just inside
    // the window edge to hit the strict comparison.
    function automatic logic [ppd_pkg::PULSE_W-1:0] near_value(input int unsigned nominal);
        int unsigned tol;
        int unsigned dev;
        int unsigned pick;
        longint      v;
        tol  = match_window();
        pick = $urandom_range(99);
        if (pick < 2)
            dev = tol;
        else if (pick < 4)
            dev = tol - 1;
        else
            dev = $urandom_range(0, tol - 1);
        v = $urandom_range(1) ? longint'(nominal) + dev : longint'(nominal) - dev;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return ppd_pkg::PULSE_W'(v);
    endfunction

    // A capture of high/low pairs with random bits. A broken capture gets a
    // corrupted, dropped or extra pulse; some captures end early or run long.
    task automatic send_capture(input bit broken);
        t_pulse      pulses[$];
        t_pulse      p;
        int unsigned need;
        int unsigned nbits;
        int unsigned pos;
        bit          one;
        need  = bits_to_complete();
        nbits = need;
        if (broken || $urandom_range(9) == 0)
            nbits = $urandom_range(0, need);
        p = '0;
        for (int i = 0; i < nbits; i++) begin
            one   = 1'($urandom_range(1));
            p.dur = near_value(one ? cfg_short : cfg_long);
            pulses.push_back(p);
            p.dur = near_value(one ? cfg_long : cfg_short);
            pulses.push_back(p);
        end
        // odd trailing high pulse
        if (pulses.size() == 0 || (nbits < need && $urandom_range(3) == 0)) begin
            p.dur = near_value($urandom_range(1) ? cfg_short : cfg_long);
            pulses.push_back(p);
        end
        if (broken) begin
            pos = $urandom_range(0, pulses.size() - 1);
            case ($urandom_range(2))
                0: pulses[pos].dur = ppd_pkg::PULSE_W'($urandom_range(0, 65535));
                1: if (pos > 0) pulses.delete(pos);
                default: begin
                    p.dur = ppd_pkg::PULSE_W'($urandom_range(0, 65535));
                    pulses.insert(pos + 1, p);
                end
            endcase
        end
        pulses[0].first = 1'b1;
        if ($urandom_range(4) != 0)
            pulses[pulses.size() - 1].last = 1'b1;
        // trailing pulses after the frame; ignored once a frame came out
        if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                p.dur  = ppd_pkg::PULSE_W'($urandom_range(0, 65535));
                p.last = 1'($urandom_range(1));
                pulses.push_back(p);
            end
        end
        foreach (pulses[i])
            send_pulse(pulses[i].dur, pulses[i].first, pulses[i].last);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_pulse(ppd_pkg::PULSE_W'($urandom_range(0, 65535)),
                       $urandom_range(3) == 0, 1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (400/1200 us, 30 %, 24 bits): idle pulses, a bad pair,
    // a lone first+last high pulse and a capture ending early.
    task automatic test_reset_defaults();
        send_pulse(16'd500,  1'b0, 1'b0);
        send_pulse(16'd1300, 1'b0, 1'b1);
        send_pulse(16'd400,  1'b1, 1'b0);
        send_pulse(16'd1200, 1'b0, 1'b0);
        send_pulse(16'd800,  1'b0, 1'b0);
        send_pulse(16'd800,  1'b0, 1'b0);
        send_pulse(16'd1200, 1'b1, 1'b1);
        send_pulse(16'd380,  1'b1, 1'b0);
        send_pulse(16'd1330, 1'b0, 1'b1);
        settle();
    endtask

    // Full-scale durations, completion on the last pulse, then an idle pulse
    task automatic test_pulse_extremes();
        load_settings(0, 65535, 0, 2, 8'hA5);
        send_pulse(16'd0,     1'b1, 1'b0);
        send_pulse(16'hFFFF,  1'b0, 1'b0);
        send_pulse(16'hFFFF,  1'b0, 1'b0);
        send_pulse(16'd0,     1'b0, 1'b1);
        send_pulse(16'hFFFF,  1'b0, 1'b0);
        settle();
    endtask

    // Zero bit count: the restarting pulse itself completes an empty frame
    task automatic test_zero_bits();
        load_settings(400, 1200, 30, 0, 8'h3C);
        send_pulse(16'd400,  1'b1, 1'b0);
        send_pulse(16'd1200, 1'b0, 1'b1);
        settle();
    endtask

    // Equal short and long times: both patterns fit and the pair decodes as
    // one; a high pulse exactly one window away fits neither.
    task automatic test_both_patterns();
        load_settings(400, 400, 30, 1, 8'h01);
        send_pulse(16'd400, 1'b1, 1'b0);
        send_pulse(16'd400, 1'b0, 1'b1);
        send_pulse(16'd550, 1'b1, 1'b0);
        send_pulse(16'd400, 1'b0, 1'b0);
        settle();
    endtask

    // Output held off for a long stretch while one-bit captures keep coming:
    // the result register fills and the pulse input has to stall.
    task automatic test_backpressure();
        load_settings(400, 1200, 30, 1, 8'h77);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 80;
        repeat (25)
            send_capture(1'b0);
        settle();
    endtask

    // Random captures over several setups, extremes first, cycling through
    // the idling patterns; keeps going while too few frames have come out.
    task automatic test_random_traffic();
        int phase;
        int quota;
        int pick;
        int unsigned st;
        int unsigned lt;
        int unsigned pct;
        int unsigned need;
        phase = 0;
        while (phase < 8 || (frames_ok + frames_failed < 60 && phase < 16)) begin
            settle();
            case (phase)
                0: load_settings(0, 65535, 0, 64, 255);
                1: load_settings(65535, 65535, 127, 127, 8'h5A);
                default: begin
                    st   = $urandom_range(0, 3000);
                    lt   = $urandom_range(1) ? st + $urandom_range(150, 6000)
                                             : $urandom_range(0, 65535);
                    pct  = ($urandom_range(9) == 0) ? $urandom_range(101, 127)
                                                     : $urandom_range(0, 100);
                    pick = $urandom_range(19);
                    if (pick == 0)
                        need = 0;
                    else if (pick == 1)
                        need = $urandom_range(65, 127);
                    else if (pick < 5)
                        need = $urandom_range(11, 64);
                    else
                        need = $urandom_range(1, 10);
                    load_settings(st, lt, pct, need, $urandom_range(0, 255));
                end
            endcase
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
                default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
            endcase
            quota = counted_pulses + 50;
            while (counted_pulses < quota) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_capture(1'b0);
                else if (pick < 85)
                    send_capture(1'b1);
                else
                    send_noise();
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        pulse_ch.valid       = 1'b0;
        pulse_ch.pulse_us    = '0;
        pulse_ch.first_pulse = 1'b0;
        pulse_ch.last_pulse  = 1'b0;
        result_ch.ready      = 1'b0;
        tx_idle_pct          = 0;
        rx_stall_pct         = 0;
        rx_hold              = 0;
        error_count          = 0;
        results_checked      = 0;
        frames_ok            = 0;
        frames_failed        = 0;
        counted_pulses       = 0;
        setups_loaded        = 0;
        reset_model();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_pulse_extremes();
        test_zero_bits();
        test_both_patterns();
        test_backpressure();
        test_random_traffic();

        settle();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d result frames (%0d decoded, %0d failed) from %0d live pulses",
                 results_checked, frames_ok, frames_failed, counted_pulses);
        $display("Over %0d register setups incl. zero and over-range bit counts, wide windows",
                 setups_loaded);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
